FILE: rtl/refcounted_page_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rpa_pkg.sv
`timescale 1ns / 1ps
package rpa_pkg;

  // Fixed field widths
  localparam int PAGE_W = 12;
  localparam int CNT_W  = 13;
  localparam int MAX_PAGES = 4096;

  // Defaults for the top-level parameters
  localparam int DEF_NUM_PAGES = 4096;
  localparam int DEF_REF_WIDTH = 16;

  // Request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_PAGE  = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  // Free-stack commands
  typedef struct packed {
    logic flush;
    logic peek;
    logic pop;
    logic push;
  } rpa_stack_cmd_t;

  // Reference-count store commands
  typedef struct packed {
    logic clear;
    logic rd_en;
    logic wr_en;
  } rpa_ref_cmd_t;

endpackage

FILE: rtl/rpa_ref_store.sv
`timescale 1ns / 1ps
module rpa_ref_store import rpa_pkg::*; #(
  parameter int DEPTH     = DEF_NUM_PAGES,
  parameter int REF_WIDTH = DEF_REF_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rpa_ref_cmd_t             cmd,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [REF_WIDTH-1:0]     wr_data,
  output logic [REF_WIDTH-1:0]     rd_data,
  output logic                     clearing
);

  localparam int AW = $clog2(DEPTH);

  logic [REF_WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]        clr_addr;
  logic [REF_WIDTH-1:0] clr_data;

  // Page one keeps its permanent reference
  assign clr_data = (clr_addr == AW'(1)) ? REF_WIDTH'(1) : '0;

  // Clearing sweep, one entry per cycle after reset or re-init
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= clr_data;
    end else if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/rpa_free_stack.sv
`timescale 1ns / 1ps
module rpa_free_stack import rpa_pkg::*; #(
  parameter int DEPTH = DEF_NUM_PAGES
) (
  input  logic              clk,
  input  logic              rst,
  input  rpa_stack_cmd_t    cmd,
  input  logic [PAGE_W-1:0] push_data,
  output logic [PAGE_W-1:0] top_data,
  output logic              empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int DW = $clog2(DEPTH + 1);

  logic [PAGE_W-1:0] mem [DEPTH];
  logic [DW-1:0]     depth;
  logic [AW-1:0]     top_addr;
  logic              full;

  assign top_addr = AW'(depth - DW'(1));
  assign full     = (depth == DW'(DEPTH));
  assign empty    = (depth == '0);

  // Stack pointer; a push onto a full stack is dropped
  always_ff @(posedge clk) begin
    if (rst || cmd.flush) begin
      depth <= '0;
    end else if (cmd.pop && !empty) begin
      depth <= depth - DW'(1);
    end else if (cmd.push && !full) begin
      depth <= depth + DW'(1);
    end
  end

  // Push write
  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[depth[AW-1:0]] <= push_data;
    end
  end

  // Top-of-stack read, registered
  always_ff @(posedge clk) begin
    if (cmd.peek) begin
      top_data <= mem[top_addr];
    end
  end

endmodule

FILE: rtl/refcounted_page_allocator.sv
`timescale 1ns / 1ps
// Reference-counted page allocator. A transaction is taken when start is high
// and busy is low. Its result is registered at the edge after the accepting
// edge and is shown on the result ports with done high for exactly one cycle.
// It cannot be held off, so the receiver must capture it then. Busy holds off
// a new transaction until the last one is executed: the accepting cycle reads
// the free stack or the reference count from synchronous memory, and the
// execute state updates memory and registers the result.
// After reset is released the block holds busy high while it sweeps all
// min(NUM_PAGES, 4096) entries of the reference-count memory, one entry per
// cycle. A write of page_count re-initializes the block the same way, and busy
// stays high for the write cycle plus that sweep.
`include "refcounted_page_allocator_defines.svh"
module refcounted_page_allocator import rpa_pkg::*; #(
  parameter int NUM_PAGES = DEF_NUM_PAGES,
  parameter int REF_WIDTH = DEF_REF_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              start,
  input  logic              req_type,
  input  logic [PAGE_W-1:0] page_id,
  output logic              busy,
  output logic              done,
  output logic [PAGE_W-1:0] granted_page,
  output logic [1:0]        status,
  output logic              released,
  output logic [CNT_W-1:0]  pages_left
);

  localparam int DEPTH = (NUM_PAGES < MAX_PAGES) ? NUM_PAGES : MAX_PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] TOP_PAGES = CNT_W'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                 state;
  logic                 accept;
  logic                 req_r;
  logic [PAGE_W-1:0]    idx_r;
  logic [CNT_W-1:0]     page_count;
  logic [CNT_W-1:0]     fresh_pointer;
  logic [CNT_W-1:0]     allocated_pages;
  logic [CNT_W-1:0]     allocated_next;
  logic [CNT_W-1:0]     cfg_clamped;

  rpa_stack_cmd_t       stk_cmd;
  logic [PAGE_W-1:0]    stk_top;
  logic                 stk_empty;
  rpa_ref_cmd_t         ref_cmd;
  logic [REF_WIDTH-1:0] ref_rd;
  logic [REF_WIDTH-1:0] ref_wdata;
  logic [AW-1:0]        ref_waddr;
  logic                 clearing;

  logic                 from_stack;
  logic                 have_page;
  logic [PAGE_W-1:0]    pick;
  logic                 bad_free;
  logic [REF_WIDTH-1:0] ref_dec;
  logic                 drop_zero;
  logic [1:0]           status_next;

  assign busy   = rst || cfg_we || clearing || (state == S_EXEC);
  assign accept = start && !busy;

  // Register value clamped to the supported range
  assign cfg_clamped = (cfg_wdata < CNT_W'(3)) ? CNT_W'(3) :
                       (cfg_wdata > TOP_PAGES) ? TOP_PAGES : cfg_wdata;

  // Allocate: pop the stack first, else take the next fresh page
  assign from_stack = !stk_empty;
  assign have_page  = from_stack || (fresh_pointer >= CNT_W'(2));
  assign pick       = from_stack ? stk_top : fresh_pointer[PAGE_W-1:0];

  // Free: range and count checks
  assign bad_free  = (idx_r < PAGE_W'(2)) || ({1'b0, idx_r} >= page_count) ||
                     (ref_rd == '0);
  assign ref_dec   = ref_rd - REF_WIDTH'(1);
  assign drop_zero = (ref_dec == '0);

  always_comb begin
    allocated_next = allocated_pages;
    status_next    = STATUS_OK;
    if (req_r == REQ_ALLOC) begin
      if (have_page) begin
        allocated_next = allocated_pages + CNT_W'(1);
      end else begin
        status_next = STATUS_NO_PAGE;
      end
    end else if (bad_free) begin
      status_next = STATUS_BAD_FREE;
    end else if (drop_zero && (allocated_pages != '0)) begin
      allocated_next = allocated_pages - CNT_W'(1);
    end
  end

  // Memory commands: reads on accept, writes in the execute cycle, flush and clear on a page_count write
  always_comb begin
    stk_cmd.flush = cfg_we;
    stk_cmd.peek  = accept && (req_type == REQ_ALLOC);
    stk_cmd.pop   = (state == S_EXEC) && (req_r == REQ_ALLOC) && from_stack;
    stk_cmd.push  = (state == S_EXEC) && (req_r == REQ_FREE) && !bad_free && drop_zero;
    ref_cmd.clear = cfg_we;
    ref_cmd.rd_en = accept && (req_type == REQ_FREE);
    ref_cmd.wr_en = (state == S_EXEC) &&
                    (((req_r == REQ_ALLOC) && have_page) ||
                     ((req_r == REQ_FREE) && !bad_free));
    // A page handed out always held zero references
    ref_waddr     = (req_r == REQ_ALLOC) ? pick[AW-1:0] : idx_r[AW-1:0];
    ref_wdata     = (req_r == REQ_ALLOC) ? REF_WIDTH'(1) : ref_dec;
  end

  rpa_free_stack #(
    .DEPTH(DEPTH)
  ) u_stack (
    .clk      (clk),
    .rst      (rst),
    .cmd      (stk_cmd),
    .push_data(idx_r),
    .top_data (stk_top),
    .empty    (stk_empty)
  );

  rpa_ref_store #(
    .DEPTH    (DEPTH),
    .REF_WIDTH(REF_WIDTH)
  ) u_refs (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ref_cmd),
    .rd_addr (page_id[AW-1:0]),
    .wr_addr (ref_waddr),
    .wr_data (ref_wdata),
    .rd_data (ref_rd),
    .clearing(clearing)
  );

  // Sequencer and allocator counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      done            <= 1'b0;
      page_count      <= TOP_PAGES;
      fresh_pointer   <= TOP_PAGES - CNT_W'(1);
      allocated_pages <= '0;
    end else if (cfg_we) begin
      state           <= S_IDLE;
      done            <= 1'b0;
      page_count      <= cfg_clamped;
      fresh_pointer   <= cfg_clamped - CNT_W'(1);
      allocated_pages <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state           <= S_IDLE;
          done            <= 1'b1;
          allocated_pages <= allocated_next;
          if ((req_r == REQ_ALLOC) && !from_stack && have_page) begin
            fresh_pointer <= fresh_pointer - CNT_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request capture and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_type;
      idx_r <= page_id;
    end
    if (state == S_EXEC) begin
      granted_page <= ((req_r == REQ_ALLOC) && have_page) ? pick : '0;
      status       <= status_next;
      released     <= (req_r == REQ_FREE) && !bad_free && drop_zero;
      pages_left   <= page_count - allocated_next;
    end
  end

  // Checks
  `RPA_ASSERT_NEXT(a_accept_exec, accept, (state == S_EXEC) && busy, "no execute after accept")
  `RPA_ASSERT_NEXT(a_exec_done, (state == S_EXEC) && !cfg_we, done, "no strobe after execute")
  `RPA_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `RPA_ASSERT_NOW(a_alloc_bound, 1'b1, allocated_pages <= page_count, "too many pages allocated")
  `RPA_ASSERT_NOW(a_grant_ok, done && (status != STATUS_OK), granted_page == '0, "grant on error")

endmodule

FILE: tb/refcounted_page_allocator_test.sv
`timescale 1ns / 1ps
module refcounted_page_allocator_test;
  import rpa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam logic [15:0] REF_MAX = 16'hFFFF;

  // One request and one allocator response, as carried on the ports
  typedef struct packed {
    logic              rq;
    logic [PAGE_W-1:0] idx;
  } page_req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] granted;
    logic [1:0]        st;
    logic              rel;
    logic [CNT_W-1:0]  left;
  } grant_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata = '0;
  logic              start = 1'b0;
  logic              req_type = 1'b0;
  logic [PAGE_W-1:0] page_id = '0;
  logic              busy;
  logic              done;
  logic [PAGE_W-1:0] granted_page;
  logic [1:0]        status;
  logic              released;
  logic [CNT_W-1:0]  pages_left;

  refcounted_page_allocator uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .start(start),
    .req_type(req_type),
    .page_id(page_id),
    .busy(busy),
    .done(done),
    .granted_page(granted_page),
    .status(status),
    .released(released),
    .pages_left(pages_left)
  );

  // Shadow allocator state
  logic [CNT_W-1:0]  pg_count;
  logic [PAGE_W-1:0] freed_stack [MAX_PAGES];
  logic [CNT_W-1:0]  freed_depth;
  logic [CNT_W-1:0]  fresh_ptr;
  logic [15:0]       ref_cnt [MAX_PAGES];
  logic [CNT_W-1:0]  alloc_cnt;
  logic [PAGE_W-1:0] held_pages[$];

  page_req_t     pending_reqs[$];
  grant_result_t expected_grants[$];

  int  issued_cnt = 0;
  int  accepted_cnt = 0;
  int  mismatch_cnt = 0;
  int  cycle_cnt = 0;
  int  gap_pct = 0;
  int  n_granted = 0;
  int  n_exhausted = 0;
  int  n_bad_free = 0;
  int  n_released = 0;
  int  n_settings = 0;
  logic accepted = 1'b0;

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Reload the shadow state as a page_count write (or reset) does
  task automatic load_page_count(input logic [CNT_W-1:0] v);
    int k;
    if (v < 3) pg_count = CNT_W'(3);
    else if (v > CNT_W'(MAX_PAGES)) pg_count = CNT_W'(MAX_PAGES);
    else pg_count = v;
    for (k = 0; k < MAX_PAGES; k++) ref_cnt[k] = '0;
    ref_cnt[1] = 16'd1;
    freed_depth = '0;
    fresh_ptr = pg_count - CNT_W'(1);
    alloc_cnt = '0;
    held_pages.delete();
  endtask

  // Work out the response to one accepted request and queue it
  task automatic predict_grant(input logic rq, input logic [PAGE_W-1:0] idx);
    grant_result_t r;
    logic [PAGE_W-1:0] pg;
    logic have;
    logic found;
    int k;
    r = '0;
    pg = '0;
    have = 1'b0;
    found = 1'b0;
    if (rq == REQ_ALLOC) begin
      // freed pages first, then never-used pages counting down
      if (freed_depth > 0) begin
        freed_depth = freed_depth - CNT_W'(1);
        pg = freed_stack[freed_depth[PAGE_W-1:0]];
        have = 1'b1;
      end else if (fresh_ptr >= 2) begin
        pg = fresh_ptr[PAGE_W-1:0];
        fresh_ptr = fresh_ptr - CNT_W'(1);
        have = 1'b1;
      end
      if (have) begin
        if (ref_cnt[pg] != REF_MAX) ref_cnt[pg] = ref_cnt[pg] + 16'd1;
        if (alloc_cnt != '1) alloc_cnt = alloc_cnt + CNT_W'(1);
        r.granted = pg;
        r.st = STATUS_OK;
        held_pages.push_back(pg);
        n_granted++;
      end else begin
        r.st = STATUS_NO_PAGE;
        n_exhausted++;
      end
    end else if (idx < 2 || {1'b0, idx} >= pg_count || ref_cnt[idx] == 0) begin
      r.st = STATUS_BAD_FREE;
      n_bad_free++;
    end else begin
      r.st = STATUS_OK;
      ref_cnt[idx] = ref_cnt[idx] - 16'd1;
      if (ref_cnt[idx] == 0) begin
        if (freed_depth < CNT_W'(MAX_PAGES)) begin
          freed_stack[freed_depth[PAGE_W-1:0]] = idx;
          freed_depth = freed_depth + CNT_W'(1);
        end
        if (alloc_cnt != 0) alloc_cnt = alloc_cnt - CNT_W'(1);
        r.rel = 1'b1;
        n_released++;
        for (k = 0; k < held_pages.size(); k++) begin
          if (!found && held_pages[k] == idx) begin
            held_pages.delete(k);
            found = 1'b1;
          end
        end
      end
    end
    r.left = pg_count - alloc_cnt;
    expected_grants.push_back(r);
  endtask

  // Driver: present requests at the falling edge, hold until taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || accepted) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
        start <= 1'b1;
        req_type <= pending_reqs[0].rq;
        page_id <= pending_reqs[0].idx;
        void'(pending_reqs.pop_front());
      end else begin
        start <= 1'b0;
        req_type <= 1'($urandom_range(0, 1));
        page_id <= PAGE_W'($urandom_range(0, 4095));
      end
    end
  end

  // Monitor: check responses, predict on each accepted transaction
  always @(posedge clk) begin
    grant_result_t want;
    grant_result_t got;
    cycle_cnt++;
    accepted <= start && !busy && !rst;
    if (!rst && done) begin
      got = '{granted_page, status, released, pages_left};
      if (expected_grants.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("[%0t] response with none pending: page=%0d status=%0d rel=%0b left=%0d",
                   $realtime, got.granted, got.st, got.rel, got.left);
      end else begin
        want = expected_grants.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display({"[%0t] mismatch: exp page=%0d status=%0d rel=%0b left=%0d,",
                      " got page=%0d status=%0d rel=%0b left=%0d"},
                     $realtime, want.granted, want.st, want.rel, want.left,
                     got.granted, got.st, got.rel, got.left);
        end
      end
    end
    if (!rst && start && !busy) begin
      predict_grant(req_type, page_id);
      accepted_cnt++;
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_req(input logic rq, input logic [PAGE_W-1:0] idx);
    page_req_t t;
    t.rq = rq;
    t.idx = idx;
    pending_reqs.push_back(t);
    issued_cnt++;
  endtask

  // Wait until every transaction is taken and answered
  task automatic drain;
    while (accepted_cnt != issued_cnt || expected_grants.size() != 0 || start)
      @(posedge clk);
  endtask

  task automatic write_page_count(input logic [CNT_W-1:0] v);
    drain();
    while (busy) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    load_page_count(v);
    n_settings++;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= CNT_W'($urandom_range(0, 8191));
  endtask

  // Random traffic: allocations at alloc_pct percent, frees of held pages, some noise frees
  task automatic random_traffic(input int n, input int alloc_pct);
    int i;
    int r;
    logic [PAGE_W-1:0] idx;
    for (i = 0; i < n; i++) begin
      while (pending_reqs.size() >= 2) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
        queue_req(REQ_ALLOC, PAGE_W'($urandom_range(0, 4095)));
      end else if (r < 90 && held_pages.size() > 0) begin
        queue_req(REQ_FREE, held_pages[$urandom_range(0, held_pages.size() - 1)]);
      end else begin
        if ($urandom_range(0, 1)) idx = PAGE_W'($urandom_range(0, 4095));
        else idx = PAGE_W'($urandom_range(0, pg_count + 1));
        queue_req(REQ_FREE, idx);
      end
    end
  endtask

  // Stimulus
  initial begin
    logic [CNT_W-1:0] cfg_vals [8];
    int alloc_bias [3];
    int gaps [3];
    int p;
    cfg_vals = '{13'd8191, 13'd4, 13'd10, 13'd37, 13'd4096, 13'd200, 13'd3, 13'd600};
    alloc_bias = '{50, 65, 40};
    gaps = '{0, 49, 9};
    load_page_count(13'd4096);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset page count: fresh pages, stack reuse, reserved and stale frees
    queue_req(REQ_ALLOC, 12'd0);
    queue_req(REQ_ALLOC, 12'hFFF);
    queue_req(REQ_FREE, 12'd4094);
    queue_req(REQ_ALLOC, 12'd0);
    queue_req(REQ_FREE, 12'd0);
    queue_req(REQ_FREE, 12'd1);
    queue_req(REQ_FREE, 12'd4095);
    queue_req(REQ_FREE, 12'd4095);
    queue_req(REQ_FREE, 12'd100);

    // Directed, page count below minimum clamps to three: exhaustion and range
    write_page_count(13'd0);
    queue_req(REQ_ALLOC, 12'd0);
    queue_req(REQ_ALLOC, 12'd0);
    queue_req(REQ_FREE, 12'd3);
    queue_req(REQ_FREE, 12'hFFF);
    queue_req(REQ_FREE, 12'd2);
    queue_req(REQ_FREE, 12'd2);
    queue_req(REQ_ALLOC, 12'd0);
    queue_req(REQ_ALLOC, 12'hFFF);
    queue_req(REQ_FREE, 12'd2);

    // Random phases over several page counts and sender gap rates
    for (p = 0; p < 8; p++) begin
      write_page_count(cfg_vals[p]);
      gap_pct = gaps[p % 3];
      random_traffic(112, alloc_bias[p % 3]);
    end
    drain();
    gap_pct = 0;
    repeat (10) @(posedge clk);

    $display("Covered %0d requests over %0d page_count settings plus reset default.",
             accepted_cnt, n_settings);
    $display("Grants %0d, exhaustions %0d, bad frees %0d, releases %0d, mismatches %0d.",
             n_granted, n_exhausted, n_bad_free, n_released, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_grants.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
